[sv/circular_motion_generator_unit_defines.svh]
// Assertion macros for the circular motion generator.
`ifndef CIRCULAR_MOTION_GENERATOR_UNIT_DEFINES_SVH
`define CIRCULAR_MOTION_GENERATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CMG_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CMG_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CMG_ASSERT(label, clk, rst_n, prop, msg)
`define CMG_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

[sv/cmg_pkg.sv]
// Package: types, constants and tables for the circular motion generator.
package cmg_pkg;
    localparam int unsigned CordicStepsDefault = 16;
    localparam int unsigned AtanLen = 24;
    localparam logic [18:0] TwoPiQ16 = 19'd411775;
    localparam logic [17:0] PiQ16 = 18'd205887;
    localparam logic [16:0] HalfPiQ16 = 17'd102944;
    localparam logic signed [33:0] CordicGainQ30 = 34'sd652032874;

    typedef enum logic [2:0] {
        REG_RADIUS = 3'd0, REG_PERIOD = 3'd1, REG_TARGET = 3'd2, REG_START = 3'd3,
        REG_CENTER_X = 3'd4, REG_CENTER_Y = 3'd5, REG_DIRECTION = 3'd6
    } t_reg_idx;

    typedef enum logic [0:0] { REQ_TICK = 1'b0, REQ_RESTART = 1'b1 } t_req;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_ANGLE, ST_REDUCE, ST_CORDIC, ST_MULX, ST_MULY, ST_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [41:0] dividend;
        logic [23:0] divisor;
    } t_div_ctl;

    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        case (i)
            5'd0: atan_q30 = 30'd843314857;
            5'd1: atan_q30 = 30'd497837829;
            5'd2: atan_q30 = 30'd263043837;
            5'd3: atan_q30 = 30'd133525159;
            5'd4: atan_q30 = 30'd67021687;
            5'd5: atan_q30 = 30'd33543516;
            5'd6: atan_q30 = 30'd16775851;
            5'd7: atan_q30 = 30'd8388437;
            5'd8: atan_q30 = 30'd4194283;
            5'd9: atan_q30 = 30'd2097149;
            5'd10: atan_q30 = 30'd1048576;
            5'd11: atan_q30 = 30'd524288;
            5'd12: atan_q30 = 30'd262144;
            5'd13: atan_q30 = 30'd131072;
            5'd14: atan_q30 = 30'd65536;
            5'd15: atan_q30 = 30'd32768;
            5'd16: atan_q30 = 30'd16384;
            5'd17: atan_q30 = 30'd8192;
            5'd18: atan_q30 = 30'd4096;
            5'd19: atan_q30 = 30'd2048;
            5'd20: atan_q30 = 30'd1024;
            5'd21: atan_q30 = 30'd512;
            5'd22: atan_q30 = 30'd256;
            5'd23: atan_q30 = 30'd128;
            default: atan_q30 = 30'd0;
        endcase
    endfunction
endpackage

[sv/cmg_req_if.sv]
// Request channel: tick or restart word.
interface cmg_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] delta_time;
    modport source (output valid, req_type, delta_time, input ready);
    modport sink (input valid, req_type, delta_time, output ready);
endinterface

[sv/cmg_pos_if.sv]
// Result channel: position word.
interface cmg_pos_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic               pos_updated;
    logic               finished;
    modport source (output valid, pos_x, pos_y, pos_updated, finished, input ready);
    modport sink (input valid, pos_x, pos_y, pos_updated, finished, output ready);
endinterface

[sv/circular_motion_generator_unit.sv]
// Top level: circular motion generator with one divider and a CORDIC loop.
//  channel | dir | word
//  i_req   | in  | req_type, delta_time
//  o_pos   | out | pos_x, pos_y, pos_updated, finished
//  cfg     | in  | i_cfg_we, i_cfg_idx, i_cfg_data (no read-back)
// A tick with a position runs through the bit-serial divider, the range-reduction
// subtracts, the CORDIC iterations, both multiplies and the output state. A tick
// that finishes stops after the divider; restart and zero period never start it.
// Reset is synchronous; no new word is taken until the result is taken.
module circular_motion_generator_unit
    import cmg_pkg::*;
#(
    parameter int unsigned CORDIC_STEPS = CordicStepsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    cmg_req_if.sink     i_req,
    cmg_pos_if.source   o_pos
);
    `include "circular_motion_generator_unit_defines.svh"
    localparam int unsigned NSteps = (CORDIC_STEPS < AtanLen) ? CORDIC_STEPS : AtanLen;
    localparam logic [4:0] LastStep = 5'(NSteps - 1);
    localparam logic signed [19:0] PiS = 20'(signed'({1'b0, PiQ16}));
    localparam logic signed [19:0] TwoPiS = 20'(signed'({1'b0, PiQ16, 1'b0}));
    localparam logic signed [19:0] HalfPiS = 20'(signed'({1'b0, HalfPiQ16}));

    logic [19:0] r_radius;
    logic [23:0] r_period;
    logic signed [23:0] r_target, r_start, r_cx, r_cy;
    logic r_dir;

    t_state r_state, n_state;
    logic signed [23:0] r_angle;
    logic r_done;
    logic [15:0] r_dt;
    logic r_neg;
    logic signed [33:0] r_x, r_y;
    logic signed [31:0] r_z;
    logic [4:0] r_i;
    logic signed [55:0] r_prod;
    logic signed [23:0] r_px, r_py;
    logic r_upd, r_vld;

    t_div_ctl w_div;
    logic w_div_done;
    logic [41:0] w_quot;

    cmg_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_div),
        .o_done(w_div_done), .o_quot(w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0; r_period <= '0; r_target <= '0; r_start <= '0;
            r_cx <= '0; r_cy <= '0; r_dir <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RADIUS: r_radius <= i_cfg_data[19:0];
                REG_PERIOD: r_period <= i_cfg_data;
                REG_TARGET: r_target <= i_cfg_data;
                REG_START: r_start <= i_cfg_data;
                REG_CENTER_X: r_cx <= i_cfg_data;
                REG_CENTER_Y: r_cy <= i_cfg_data;
                REG_DIRECTION: r_dir <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic w_acc, w_take;
    assign i_req.ready = (r_state == ST_IDLE) && !r_vld;
    assign w_acc = i_req.valid && i_req.ready;
    assign w_take = o_pos.valid && o_pos.ready;

    // step saturation and angle update
    logic [23:0] w_step;
    logic signed [25:0] w_sum;
    logic signed [23:0] w_new;
    logic w_pass;
    assign w_step = (w_quot > 42'd8388607) ? 24'd8388607 : w_quot[23:0];
    assign w_sum = r_dir ? (26'(r_angle) + 26'(signed'({1'b0, w_step})))
                         : (26'(r_angle) - 26'(signed'({1'b0, w_step})));
    assign w_new = (w_sum > 26'sd8388607) ? 24'sh7FFFFF :
                   (w_sum < -26'sd8388608) ? 24'sh800000 : w_sum[23:0];
    assign w_pass = r_dir ? (w_new > r_target) : (w_new < r_target);

    // range reduction: truncating remainder by 2*pi, then fold
    logic signed [19:0] w_r1;
    logic signed [19:0] w_r2;
    logic w_fold;
    logic signed [19:0] w_r3;
    // magnitude at most 2^23 so at most 20 subtractions of 2*pi; done as a loop over
    // the reduce state, one subtract per cycle
    logic [23:0] r_mag;

    logic signed [33:0] w_dx, w_dy;
    assign w_dx = r_y >>> r_i;
    assign w_dy = r_x >>> r_i;

    always_comb begin
        n_state = r_state;
        w_div.start = 1'b0;
        w_div.dividend = 42'(TwoPiQ16 * r_dt);
        w_div.divisor = r_period;
        case (r_state)
            ST_IDLE: if (w_acc && i_req.req_type == REQ_TICK && r_period != '0) begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                w_div.start = 1'b1;
                n_state = ST_ANGLE;
            end
            ST_ANGLE: if (w_div_done) begin
                n_state = (r_done || w_pass) ? ST_IDLE : ST_REDUCE;
            end
            ST_REDUCE: if (r_mag < 24'({PiQ16, 1'b0}) ) begin
                n_state = ST_CORDIC;
            end
            ST_CORDIC: if (r_i == LastStep) begin
                n_state = ST_MULX;
            end
            ST_MULX: n_state = ST_MULY;
            ST_MULY: n_state = ST_OUT;
            ST_OUT: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign w_r1 = r_angle[23] ? -20'(r_mag) : 20'(r_mag);
    assign w_r2 = (w_r1 > PiS) ? w_r1 - TwoPiS :
                  (w_r1 < -PiS) ? w_r1 + TwoPiS : w_r1;
    assign w_fold = (w_r2 > HalfPiS) || (w_r2 < -HalfPiS);
    assign w_r3 = (w_r2 > HalfPiS) ? w_r2 - PiS :
                  (w_r2 < -HalfPiS) ? w_r2 + PiS : w_r2;

    // one multiplier: cos term in ST_MULX, sin term in ST_MULY
    logic signed [33:0] w_trig;
    logic signed [23:0] w_ctr;
    logic signed [56:0] w_pos;
    logic signed [23:0] w_sat;
    assign w_trig = (r_state == ST_MULX) ? (r_neg ? -r_x : r_x) : (r_neg ? -r_y : r_y);
    assign w_ctr = (r_state == ST_MULY) ? r_cx : r_cy;
    assign w_pos = 57'(w_ctr) + 57'((r_prod + 56'sd536870912) >>> 30);
    assign w_sat = (w_pos > 57'sd8388607) ? 24'sh7FFFFF :
                   (w_pos < -57'sd8388608) ? 24'sh800000 : w_pos[23:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_angle <= '0;
            r_done <= 1'b0;
            r_vld <= 1'b0;
            r_upd <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_take) begin
                r_vld <= 1'b0;
            end
            if (w_acc) begin
                r_upd <= 1'b0;
                if (i_req.req_type == REQ_RESTART) begin
                    r_angle <= r_start;
                    r_done <= 1'b0;
                    r_vld <= 1'b1;
                end else if (r_period == '0) begin
                    r_done <= 1'b1;
                    r_vld <= 1'b1;
                end
            end
            if (r_state == ST_ANGLE && w_div_done) begin
                r_angle <= w_new;
                if (w_pass) begin
                    r_done <= 1'b1;
                end
                if (r_done || w_pass) begin
                    r_vld <= 1'b1;
                end
            end
            if (r_state == ST_OUT) begin
                r_vld <= 1'b1;
                r_upd <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_dt <= i_req.delta_time;
            r_px <= '0;
            r_py <= '0;
        end
        if (r_state == ST_ANGLE && w_div_done) begin
            r_mag <= w_new[23] ? 24'(-w_new) : 24'(w_new);
        end
        if (r_state == ST_REDUCE) begin
            if (r_mag >= 24'({PiQ16, 1'b0})) begin
                r_mag <= r_mag - 24'({PiQ16, 1'b0});
            end else begin
                r_neg <= w_fold;
                r_z <= 32'(w_r3) <<< 14;
                r_x <= CordicGainQ30;
                r_y <= '0;
                r_i <= '0;
            end
        end
        if (r_state == ST_CORDIC) begin
            r_i <= r_i + 5'd1;
            if (!r_z[31]) begin
                r_x <= r_x - w_dx; r_y <= r_y + w_dy;
                r_z <= r_z - 32'(atan_q30(r_i));
            end else begin
                r_x <= r_x + w_dx; r_y <= r_y - w_dy;
                r_z <= r_z + 32'(atan_q30(r_i));
            end
        end
        if (r_state == ST_MULX || r_state == ST_MULY) begin
            r_prod <= 56'(signed'({1'b0, r_radius})) * 56'(w_trig);
        end
        if (r_state == ST_MULY) begin
            r_px <= w_sat;
        end
        if (r_state == ST_OUT) begin
            r_py <= w_sat;
        end
    end

    assign o_pos.valid = r_vld;
    assign o_pos.pos_x = r_px;
    assign o_pos.pos_y = r_py;
    assign o_pos.pos_updated = r_upd;
    assign o_pos.finished = r_done;

    `CMG_ASSERT(a_no_accept_busy, i_clk, i_rst_n, r_state != ST_IDLE |-> !i_req.ready, "ready while busy")
    `CMG_ASSERT(a_upd_not_done, i_clk, i_rst_n, (r_vld && r_upd) |-> !r_done, "position with finished set")
    `CMG_ASSERT(a_out_sets_vld, i_clk, i_rst_n, r_state == ST_OUT |=> r_vld && r_upd, "result lost")
    `CMG_ASSERT(a_noupd_zero, i_clk, i_rst_n, (r_vld && !r_upd) |-> (r_px == '0 && r_py == '0), "nonzero idle position")
endmodule

[sv/cmg_divider.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
module cmg_divider
    import cmg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_ctl    i_ctl,
    output logic        o_done,
    output logic [41:0] o_quot
);
    `include "circular_motion_generator_unit_defines.svh"
    logic [41:0] r_quot;
    logic [24:0] r_rem;
    logic [23:0] r_dvs;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [24:0] w_trial;
    logic [24:0] w_sub;

    assign w_trial = {r_rem[23:0], r_quot[41]};
    assign w_sub = w_trial - {1'b0, r_dvs};

    // done is high for one cycle once all 42 quotient bits are in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
            r_done <= 1'b0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_cnt <= 6'd42;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            r_done <= (r_cnt == 6'd1);
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_quot <= i_ctl.dividend;
            r_rem <= '0;
            r_dvs <= i_ctl.divisor;
        end else if (r_busy) begin
            if (!w_sub[24]) begin
                r_rem <= w_sub;
                r_quot <= {r_quot[40:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_quot <= {r_quot[40:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    `CMG_ASSERT(a_cnt_busy, i_clk, i_rst_n, r_busy || r_cnt == 6'd0 || $past(i_ctl.start) == 1'b0, "divider counter without busy")
    `CMG_ASSERT(a_done_end, i_clk, i_rst_n, o_done |-> !r_busy, "divider still busy at done")
    `CMG_ASSERT(a_start_busy, i_clk, i_rst_n, i_ctl.start |=> r_busy && r_cnt == 6'd42, "divider did not start")
endmodule

[test/testbench.sv]
// Testbench for the circular motion generator: directed table, random phases, self-checking.
`timescale 1ns / 1ps

module testbench;
    import cmg_pkg::*;

    localparam int unsigned Steps = 16;
    localparam longint AngMax = 8388607;
    localparam longint AngMin = -8388608;
    localparam logic [2:0] RegUnused = 3'd7;
    localparam int unsigned CycleLimit = 3000000;
    localparam int unsigned HoldCycles = 400;
    localparam int unsigned HoldAt = 250;

    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic               upd;
        logic               fin;
    } pos_word_t;

    typedef struct {
        bit          is_cfg;
        logic [2:0]  idx;
        logic [23:0] data;
        logic        req;
        logic [15:0] dt;
        bit          typed;
        pos_word_t   want;
    } stim_row_t;

    const longint arctan_q30[24] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128
    };

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [23:0] i_cfg_data;

    cmg_req_if req_ch();
    cmg_pos_if pos_ch();

    circular_motion_generator_unit u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_req(req_ch.sink),
        .o_pos(pos_ch.source)
    );

    // motion model state
    longint radius_q, period_q, target_q, start_q, cx_q, cy_q;
    bit     dir_up;
    longint angle_q;
    bit     done_q;

    pos_word_t expected_pos_q[$];
    bit failed;
    int unsigned positions_seen;
    int unsigned cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic longint sat24(longint v);
        if (v > AngMax) return AngMax;
        if (v < AngMin) return AngMin;
        return v;
    endfunction

    // Applies one word to the model and returns the position word it yields.
    function automatic pos_word_t advance_motion(logic req, logic [15:0] dt);
        pos_word_t w;
        longint st, r, x, y, z, dx, dy, px, py;
        bit neg;
        w.x = '0; w.y = '0; w.upd = 1'b0;
        if (req == REQ_RESTART) begin
            angle_q = start_q;
            done_q = 1'b0;
        end else if (period_q == 0) begin
            done_q = 1'b1;
        end else begin
            st = (longint'(411775) * longint'(dt)) / period_q;
            if (st > AngMax) st = AngMax;
            if (dir_up) begin
                angle_q = sat24(angle_q + st);
                if (angle_q > target_q) done_q = 1'b1;
            end else begin
                angle_q = sat24(angle_q - st);
                if (angle_q < target_q) done_q = 1'b1;
            end
            if (!done_q) begin
                neg = 1'b0;
                r = angle_q % (2 * 205887);
                if (r > 205887) r -= 2 * 205887;
                if (r < -205887) r += 2 * 205887;
                if (r > 102944) begin
                    r -= 205887;
                    neg = 1'b1;
                end else if (r < -102944) begin
                    r += 205887;
                    neg = 1'b1;
                end
                x = 652032874;
                y = 0;
                z = r * 16384;
                for (int i = 0; i < Steps && i < 24; i++) begin
                    dx = y >>> i;
                    dy = x >>> i;
                    if (z >= 0) begin
                        x -= dx; y += dy; z -= arctan_q30[i];
                    end else begin
                        x += dx; y -= dy; z += arctan_q30[i];
                    end
                end
                if (neg) begin
                    x = -x;
                    y = -y;
                end
                px = sat24(cx_q + ((radius_q * x + (longint'(1) << 29)) >>> 30));
                py = sat24(cy_q + ((radius_q * y + (longint'(1) << 29)) >>> 30));
                w.x = px[23:0];
                w.y = py[23:0];
                w.upd = 1'b1;
            end
        end
        w.fin = done_q;
        return w;
    endfunction

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (expected_pos_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_RADIUS:    radius_q = data[19:0];
            REG_PERIOD:    period_q = data;
            REG_TARGET:    target_q = $signed(data);
            REG_START:     start_q = $signed(data);
            REG_CENTER_X:  cx_q = $signed(data);
            REG_CENTER_Y:  cy_q = $signed(data);
            REG_DIRECTION: dir_up = data[0];
            default: ;
        endcase
    endtask

    // Offers one word after a random gap; returns once it is taken.
    task automatic send_word(logic req, logic [15:0] dt, bit typed, pos_word_t want);
        int unsigned gap;
        pos_word_t w;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= req;
        req_ch.delta_time <= dt;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        w = advance_motion(req, dt);
        expected_pos_q.push_back(typed ? want : w);
    endtask

    task automatic run_row(stim_row_t row);
        if (row.is_cfg) begin
            wait_idle();
            write_reg(row.idx, row.data);
        end else begin
            send_word(row.req, row.dt, row.typed, row.want);
        end
    endtask

    function automatic stim_row_t cfg_row(logic [2:0] idx, logic [23:0] data);
        stim_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic stim_row_t word_row(logic req, logic [15:0] dt, bit typed,
                                           logic fin);
        stim_row_t r;
        r = '{default: '0};
        r.req = req;
        r.dt = dt;
        r.typed = typed;
        r.want.fin = fin;
        return r;
    endfunction

    // receiver
    initial begin
        int unsigned gap;
        pos_word_t want;
        pos_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
            if (positions_seen == HoldAt) gap = HoldCycles;
            if (gap > 0) begin
                pos_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pos_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!pos_ch.valid) @(posedge i_clk);
            positions_seen++;
            if (expected_pos_q.size() == 0) begin
                $error("position word with no expectation waiting");
                failed = 1'b1;
            end else begin
                want = expected_pos_q.pop_front();
                if (pos_ch.pos_x !== want.x) begin
                    $error("pos_x: expected %0d actual %0d", want.x, pos_ch.pos_x);
                    failed = 1'b1;
                end
                if (pos_ch.pos_y !== want.y) begin
                    $error("pos_y: expected %0d actual %0d", want.y, pos_ch.pos_y);
                    failed = 1'b1;
                end
                if (pos_ch.pos_updated !== want.upd) begin
                    $error("pos_updated: expected %0d actual %0d", want.upd,
                           pos_ch.pos_updated);
                    failed = 1'b1;
                end
                if (pos_ch.finished !== want.fin) begin
                    $error("finished: expected %0d actual %0d", want.fin,
                           pos_ch.finished);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        stim_row_t rows[$];
        logic [23:0] tgt;
        int unsigned n_words;
        failed = 1'b0;
        positions_seen = 0;
        cycle_count = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_RADIUS;
        i_cfg_data <= '0;
        req_ch.valid <= 1'b0;
        req_ch.req_type <= REQ_TICK;
        req_ch.delta_time <= '0;
        radius_q = 0; period_q = 0; target_q = 0; start_q = 0;
        cx_q = 0; cy_q = 0; dir_up = 1'b1;
        angle_q = 0; done_q = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero period after reset finishes at once; restart clears it
        rows.push_back(word_row(REQ_TICK, 16'd0, 1, 1'b1));
        rows.push_back(word_row(REQ_TICK, 16'hFFFF, 1, 1'b1));
        rows.push_back(word_row(REQ_RESTART, 16'hFFFF, 1, 1'b0));
        rows.push_back(cfg_row(REG_RADIUS, 24'hFFFFF));
        rows.push_back(cfg_row(REG_PERIOD, 24'd1));
        rows.push_back(cfg_row(REG_CENTER_X, 24'h7FFFFF));
        rows.push_back(cfg_row(REG_CENTER_Y, 24'h800000));
        rows.push_back(cfg_row(REG_TARGET, 24'h7FFFFF));
        rows.push_back(cfg_row(REG_START, 24'h000000));
        rows.push_back(cfg_row(RegUnused, 24'hFFFFFF));
        // step saturates, angle pinned at max but not past target
        rows.push_back(word_row(REQ_TICK, 16'hFFFF, 0, 1'b0));
        rows.push_back(word_row(REQ_TICK, 16'hFFFF, 0, 1'b0));
        rows.push_back(cfg_row(REG_TARGET, 24'h000000));
        rows.push_back(word_row(REQ_TICK, 16'd1, 1, 1'b1));
        // already finished: still no position
        rows.push_back(word_row(REQ_TICK, 16'd0, 1, 1'b1));
        rows.push_back(cfg_row(REG_DIRECTION, 24'd0));
        rows.push_back(cfg_row(REG_START, 24'h800000));
        rows.push_back(cfg_row(REG_TARGET, 24'h800000));
        rows.push_back(word_row(REQ_RESTART, 16'd0, 1, 1'b0));
        rows.push_back(word_row(REQ_TICK, 16'hFFFF, 0, 1'b0));
        rows.push_back(cfg_row(REG_PERIOD, 24'hFFFFFF));
        rows.push_back(cfg_row(REG_RADIUS, 24'd0));
        rows.push_back(cfg_row(REG_START, 24'h03243F));
        rows.push_back(word_row(REQ_RESTART, 16'd7, 1, 1'b0));
        rows.push_back(word_row(REQ_TICK, 16'd1, 0, 1'b0));
        rows.push_back(word_row(REQ_TICK, 16'hFFFF, 0, 1'b0));
        rows.push_back(cfg_row(REG_TARGET, 24'h7FFFFF));
        rows.push_back(word_row(REQ_TICK, 16'd1, 1, 1'b1));
        foreach (rows[i]) run_row(rows[i]);

        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            write_reg(REG_RADIUS, (ph == 1) ? 24'hFFFFF : 24'($urandom_range(0, 20'hFFFFF)));
            case ($urandom_range(0, 7))
                0: write_reg(REG_PERIOD, 24'd0);
                1: write_reg(REG_PERIOD, 24'hFFFFFF);
                2: write_reg(REG_PERIOD, 24'd1);
                default: write_reg(REG_PERIOD, 24'($urandom_range(1 << 12, 1 << 20)));
            endcase
            write_reg(REG_DIRECTION, 24'($urandom_range(0, 1)));
            if ($urandom_range(0, 1) == 0) tgt = dir_up ? 24'h7FFFFF : 24'h800000;
            else tgt = 24'($urandom);
            write_reg(REG_TARGET, tgt);
            write_reg(REG_START, 24'($urandom));
            write_reg(REG_CENTER_X, (ph == 2) ? 24'h7FFFFF : 24'($urandom));
            write_reg(REG_CENTER_Y, (ph == 2) ? 24'h800000 : 24'($urandom));
            send_word(REQ_RESTART, 16'($urandom), 0, '{default: '0});
            n_words = 105;
            for (int k = 0; k < n_words; k++) begin
                if ($urandom_range(0, 9) == 0)
                    send_word(REQ_RESTART, 16'($urandom), 0, '{default: '0});
                else if ($urandom_range(0, 1) == 0)
                    send_word(REQ_TICK, 16'($urandom_range(0, 4095)), 0, '{default: '0});
                else
                    send_word(REQ_TICK, 16'($urandom_range(0, 65535)), 0, '{default: '0});
            end
        end

        req_ch.valid <= 1'b0;
        while (expected_pos_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (!failed) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

[circular_motion_generator_unit.f]
+incdir+sv
sv/cmg_pkg.sv
sv/cmg_req_if.sv
sv/cmg_pos_if.sv
sv/cmg_divider.sv
sv/circular_motion_generator_unit.sv
test/testbench.sv
